// ===== src/bdc_pkg.sv =====
// Shared types, constants and calendar helper functions for the business day counter.
package bdc_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int COUNT_W = 22;

	// The walking year may step one past the largest input year.
	localparam int WYEAR_W = YEAR_W + 1;
	// The running count can pass the output range before saturation.
	localparam int CNT_W   = COUNT_W + 1;
	localparam int CENT_W  = 8;
	localparam int YREM_W  = 7;

	localparam logic [WYEAR_W-1:0] YEAR_OFFSET = 15'd400;
	localparam logic [12:0]        RECIP_100   = 13'd5243;
	localparam int                 RECIP_SHIFT = 19;
	localparam logic [YREM_W-1:0]  YREM_LAST   = 7'd99;
	localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_MAR   = 4'd3;
	localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
	localparam logic [DAY_W-1:0]   DAY_LONG    = 5'd31;
	localparam logic [DAY_W-1:0]   DAY_LEAPFEB = 5'd29;
	localparam logic [8:0]         YEAR_WORKDAYS = 9'd260;

	localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef struct packed {
		logic load;
		logic div;
		logic yterm;
		logic step;
		logic publish;
	} dp_cmd_t;

	typedef struct packed {
		logic walk_more;
	} dp_sts_t;

	// Remainder by 7 of a value below 64, through a reciprocal multiply.
	function automatic logic [2:0] mod7_small(input logic [5:0] x);
		logic [11:0] p;
		logic [3:0]  q;
		logic [5:0]  r;
		p = 12'(x) * 12'd37;
		q = p[11:8];
		r = x - 6'(q) * 6'd7;
		return r[2:0];
	endfunction

	// Remainder by 7 of a value below 1024.
	function automatic logic [2:0] mod7_wide(input logic [9:0] x);
		logic [21:0] p;
		logic [7:0]  q;
		logic [9:0]  r;
		p = 22'(x) * 22'd2341;
		q = p[21:14];
		r = x - 10'(q) * 10'd7;
		return r[2:0];
	endfunction

	// Leap year from the year's remainder by 100 and the low bits of its century.
	function automatic logic is_leap(input logic [YREM_W-1:0] k, input logic [1:0] j_lo);
		return ((k[1:0] == 2'd0) && (k != '0)) || ((k == '0) && (j_lo == 2'd0));
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		if (m == '0 || m > MONTH_DEC) begin
			len = DAY_LONG;
		end else if (m == MONTH_FEB && leap) begin
			len = DAY_LEAPFEB;
		end else begin
			len = MONTH_LEN[4'(m - MONTH_JAN)];
		end
		return len;
	endfunction

	// Month term of Zeller's congruence, reduced by 7. January and February
	// (and month 0) count as months 13, 14 and 12 of the previous year.
	function automatic logic [2:0] month_term(input logic [MONTH_W-1:0] m);
		logic [2:0] t;
		case (m)
			4'd0:    t = 3'd5;
			4'd1:    t = 3'd1;
			4'd2:    t = 3'd4;
			4'd3:    t = 3'd3;
			4'd4:    t = 3'd6;
			4'd5:    t = 3'd1;
			4'd6:    t = 3'd4;
			4'd7:    t = 3'd6;
			4'd8:    t = 3'd2;
			4'd9:    t = 3'd5;
			4'd10:   t = 3'd0;
			4'd11:   t = 3'd3;
			4'd12:   t = 3'd5;
			4'd13:   t = 3'd1;
			4'd14:   t = 3'd4;
			default: t = 3'd6;
		endcase
		return t;
	endfunction

	// Zeller's code 0 is Saturday and 1 is Sunday.
	function automatic logic is_workday(input logic [2:0] h);
		return h >= 3'd2;
	endfunction

endpackage

// ===== src/bdc_ctrl.sv =====
// Controller state machine of the business day counter.
module bdc_ctrl import bdc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_YTERM = 5'b00100,
		ST_WALK  = 5'b01000,
		ST_HOLD  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				state_d = ST_YTERM;
			end
			ST_YTERM: begin
				cmd.yterm = 1'b1;
				state_d   = ST_WALK;
			end
			ST_WALK: begin
				if (sts.walk_more) begin
					cmd.step = 1'b1;
				end else if (slot_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (slot_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A new result must never overwrite one that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	// An accepted transaction closes the input until the result is published.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_DIV) && !in_ready)
		else $error("input not closed after accept");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.publish))
		else $error("result shown without publish");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> sts.walk_more && (state_q == ST_WALK))
		else $error("step issued outside the walk");

endmodule

// ===== src/bdc_datapath.sv =====
// Datapath of the business day counter: date walk, weekday terms and count.
module bdc_datapath import bdc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	input  logic [YEAR_W-1:0]  start_year,
	input  logic [MONTH_W-1:0] start_month,
	input  logic [DAY_W-1:0]   start_day,
	input  logic [YEAR_W-1:0]  end_year,
	input  logic [MONTH_W-1:0] end_month,
	input  logic [DAY_W-1:0]   end_day,
	output logic [COUNT_W-1:0] weekday_count
);

	logic [WYEAR_W-1:0] y_q;
	logic [MONTH_W-1:0] m_q;
	logic [DAY_W-1:0]   d_q;
	logic [YEAR_W-1:0]  ey_q;
	logic [MONTH_W-1:0] em_q;
	logic [DAY_W-1:0]   ed_q;
	logic [CNT_W-1:0]   cnt_q;
	// Remainder and century of y + 400, and the Zeller year terms of y + 400
	// (f0) and y + 399 (f1).
	logic [YREM_W-1:0]  k_q;
	logic [CENT_W-1:0]  j_q;
	logic [2:0]         f0_q;
	logic [2:0]         f1_q;
	logic [COUNT_W-1:0] weekday_count_q;

	logic [WYEAR_W-1:0] y_off;
	logic [27:0]        prod;
	logic [CENT_W-1:0]  j_div;
	logic [YREM_W-1:0]  k_div;
	logic [9:0]         ysum;
	logic               leap_cur;
	logic [YREM_W-1:0]  k_adv;
	logic [CENT_W-1:0]  j_adv;
	logic [3:0]         f0_sum;
	logic [2:0]         f0_adv;
	logic               skip;
	logic [CNT_W-1:0]   skip_add;
	logic [DAY_W:0]     d_inc;
	logic [MONTH_W:0]   m_inc;
	logic               wrap;
	logic               yinc;
	logic               adv_year;
	logic [DAY_W-1:0]   nd;
	logic [MONTH_W-1:0] nm;
	logic [2:0]         f0_n;
	logic [2:0]         f1_n;
	logic [2:0]         yt;
	logic               day_add;

	assign sts.walk_more = {y_q, m_q, d_q} < {1'b0, ey_q, em_q, ed_q};

	// Century split by reciprocal multiply; exact for every reachable year.
	assign y_off = y_q + YEAR_OFFSET;
	assign prod  = 28'(y_off) * 28'(RECIP_100);
	assign j_div = prod[RECIP_SHIFT+CENT_W-1:RECIP_SHIFT];
	assign k_div = YREM_W'(y_off - 15'(j_div) * 15'd100);

	assign ysum     = 10'(k_q) + 10'(k_q >> 2) + 10'(j_q >> 2) + 10'(j_q) * 10'd5;
	assign leap_cur = is_leap(k_q, j_q[1:0]);

	assign k_adv  = (k_q == YREM_LAST) ? '0 : k_q + 7'd1;
	assign j_adv  = (k_q == YREM_LAST) ? j_q + 8'd1 : j_q;
	assign f0_sum = 4'(f0_q) + 4'd1 + 4'(is_leap(k_adv, j_adv[1:0]));
	assign f0_adv = (f0_sum >= 4'd7) ? 3'(f0_sum - 4'd7) : f0_sum[2:0];

	// From January 1 a whole year is taken at once: 364 days hold 260
	// weekdays, plus January 2 and, in a leap year, January 3.
	assign skip = (m_q == MONTH_JAN) && (d_q == DAY_FIRST)
		&& (16'(y_q) + 16'd1 < 16'(ey_q));
	assign skip_add = CNT_W'(YEAR_WORKDAYS)
		+ CNT_W'(is_workday(mod7_small(6'(f1_q) + 6'd3)))
		+ CNT_W'(leap_cur && is_workday(mod7_small(6'(f1_q) + 6'd4)));

	assign d_inc = 6'(d_q) + 6'd1;
	assign m_inc = 5'(m_q) + 5'd1;
	assign wrap  = d_inc > 6'(month_days(m_q, leap_cur));
	assign yinc  = wrap && (m_inc > 5'(MONTH_DEC));
	assign nd    = wrap ? DAY_FIRST : d_inc[DAY_W-1:0];
	assign nm    = !wrap ? m_q : (yinc ? MONTH_JAN : m_inc[MONTH_W-1:0]);
	assign f0_n  = yinc ? f0_adv : f0_q;
	assign f1_n  = yinc ? f0_q : f1_q;
	assign yt    = (nm < MONTH_MAR) ? f1_n : f0_n;
	assign day_add = is_workday(mod7_small(6'(nd) + 6'(month_term(nm)) + 6'(yt)));

	assign adv_year = skip || yinc;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			y_q   <= WYEAR_W'(start_year);
			m_q   <= start_month;
			d_q   <= start_day;
			ey_q  <= end_year;
			em_q  <= end_month;
			ed_q  <= end_day;
			cnt_q <= '0;
		end
		if (cmd.div) begin
			k_q <= k_div;
			j_q <= j_div;
		end
		if (cmd.yterm) begin
			f0_q <= mod7_wide(ysum);
			// One year back shifts the term by one day, two over a leap day.
			f1_q <= mod7_wide(ysum + 10'd6 - 10'(leap_cur));
		end
		if (cmd.step) begin
			if (adv_year) begin
				y_q  <= y_q + 15'd1;
				k_q  <= k_adv;
				j_q  <= j_adv;
				f0_q <= f0_adv;
				f1_q <= f0_q;
			end
			if (skip) begin
				cnt_q <= cnt_q + skip_add;
			end else begin
				d_q   <= nd;
				m_q   <= nm;
				cnt_q <= cnt_q + CNT_W'(day_add);
			end
		end
		if (cmd.publish) begin
			weekday_count_q <= cnt_q[CNT_W-1] ? '1 : cnt_q[COUNT_W-1:0];
		end
	end

	assign weekday_count = weekday_count_q;

	// The count only grows during the walk.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> cnt_q >= $past(cnt_q))
		else $error("count decreased");

	// Every step leaves a nonzero day and a year remainder of at most 99.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (d_q != '0) && (k_q <= YREM_LAST))
		else $error("walk reached an impossible date");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && skip) |=> (m_q == MONTH_JAN) && (d_q == DAY_FIRST))
		else $error("year run left January 1");

endmodule

// ===== src/business_day_counter.sv =====
// Business day counter: weekdays after a start date up to and including an end date.
//
// Usage: a transaction on the input channel (in_valid, in_ready) carries a start
// and an end date as year, month and day. One result transaction on the output
// channel (out_valid, out_ready) returns weekday_count, the number of Monday to
// Friday days after the start date up to and including the end date, or 0 when
// the end date is not after the start date. The count saturates at 4194303.
// Sequence: after the accept, the DIV state splits the start year into century
// terms and the YTERM state forms the year terms; then the walk steps through the
// calendar one day at a time, except that a whole year starting on January 1 is
// taken in one step; a publish then loads the result register.
// One query is in work at a time; the next is accepted once the result is loaded,
// even while that result still waits to be taken. The day walk is the limit on
// throughput.
// Reset clears the controller and the result valid flag; the block then
// idles with in_ready high. A stalled receiver holds the result register, and
// a finished query waits in the controller until the register frees up.
module business_day_counter import bdc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [YEAR_W-1:0]  start_year,
	input  logic [MONTH_W-1:0] start_month,
	input  logic [DAY_W-1:0]   start_day,
	input  logic [YEAR_W-1:0]  end_year,
	input  logic [MONTH_W-1:0] end_month,
	input  logic [DAY_W-1:0]   end_day,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COUNT_W-1:0] weekday_count
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	bdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bdc_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.start_year    (start_year),
		.start_month   (start_month),
		.start_day     (start_day),
		.end_year      (end_year),
		.end_month     (end_month),
		.end_day       (end_day),
		.weekday_count (weekday_count)
	);

endmodule
